>>> design/tlbpt_pkg.sv
// tlbpt_pkg: shared constants, default sizes and the result code type for the
// address translator. Depends on nothing; imported by the translator and its testbench.
package tlbpt_pkg;

    // default sizes of the translator
    localparam int TLB_DEPTH_DEF   = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 256;
    localparam int OFFSET_BITS_DEF = 8;

    // fixed widths of the request and result fields
    localparam int ADDR_W      = 16;
    localparam int FRAME_OUT_W = 8;
    localparam int PHYS_W      = 16;
    localparam int PAGE_OUT_W  = 8;
    localparam int COUNT_W     = 32;

    // how a translation was resolved
    typedef enum logic [1:0] {
        OUT_TLB_HIT    = 2'd0,
        OUT_PT_HIT     = 2'd1,
        OUT_FAULT_LOAD = 2'd2,
        OUT_NO_FRAME   = 2'd3
    } t_outcome;

endpackage

>>> design/tlbpt_ram.sv
// tlbpt_ram: generic single-write, single-read RAM with a registered read port.
// Depends on no package.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while no read is asked for
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tlbpt_cell.sv
// tlbpt_cell: one TLB entry of the shifting entry chain (valid, page tag, frame).
// Depends on no package; instantiated by tlbpt_tlb.
module tlbpt_cell #(
    parameter int PAGE_W  = 8,
    parameter int FRAME_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_prev_valid,
    input  logic [PAGE_W-1:0]  i_prev_tag,
    input  logic [FRAME_W-1:0] i_prev_frame,
    input  logic [PAGE_W-1:0]  i_page,
    output logic               o_valid,
    output logic [PAGE_W-1:0]  o_tag,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_match
);

    logic               r_valid;
    logic [PAGE_W-1:0]  r_tag;
    logic [FRAME_W-1:0] r_frame;

    // valid bit, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    // tag and frame take the neighbour's entry on an insert
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag   <= i_prev_tag;
            r_frame <= i_prev_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_frame = r_frame;
    assign o_match = r_valid && (r_tag == i_page);

endmodule

>>> design/tlbpt_tlb.sv
// tlbpt_tlb: TLB as a chain of entry cells; inserts shift the chain so the
// oldest entry drops off the end. Depends on tlbpt_cell.
module tlbpt_tlb #(
    parameter int TLB_DEPTH = 16,
    parameter int PAGE_W    = 8,
    parameter int FRAME_W   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_lookup_en,
    input  logic [PAGE_W-1:0]  i_lookup_page,
    input  logic               i_insert_en,
    input  logic [PAGE_W-1:0]  i_insert_page,
    input  logic [FRAME_W-1:0] i_insert_frame,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_hit_frame
);

    logic               c_valid [TLB_DEPTH+1];
    logic [PAGE_W-1:0]  c_tag   [TLB_DEPTH+1];
    logic [FRAME_W-1:0] c_frame [TLB_DEPTH+1];
    logic [TLB_DEPTH-1:0] match;
    logic               any_hit;
    logic [FRAME_W-1:0] hit_frame;
    logic               r_hit;
    logic [FRAME_W-1:0] r_hit_frame;

    // head of the chain is the entry being inserted
    assign c_valid[0] = 1'b1;
    assign c_tag[0]   = i_insert_page;
    assign c_frame[0] = i_insert_frame;

    for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
        tlbpt_cell #(
            .PAGE_W (PAGE_W),
            .FRAME_W(FRAME_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (i_insert_en),
            .i_prev_valid(c_valid[g]),
            .i_prev_tag  (c_tag[g]),
            .i_prev_frame(c_frame[g]),
            .i_page      (i_lookup_page),
            .o_valid     (c_valid[g+1]),
            .o_tag       (c_tag[g+1]),
            .o_frame     (c_frame[g+1]),
            .o_match     (match[g])
        );
    end

    // a page sits in at most one entry, so the matching frames can be or-ed
    always_comb begin
        hit_frame = '0;
        for (int k = 0; k < TLB_DEPTH; k++) begin
            hit_frame = hit_frame | (match[k] ? c_frame[k+1] : '0);
        end
        any_hit = |match;
    end

    // lookup result captured with the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_lookup_en) begin
            r_hit <= any_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup_en) begin
            r_hit_frame <= hit_frame;
        end
    end

    assign o_hit       = r_hit;
    assign o_hit_frame = r_hit_frame;

endmodule

>>> design/tlb_page_table_translator.sv
// Address translator: a request is accepted in the idle state and then resolved
// in the resolve state; a new request is not accepted until the last one is
// resolved. The TLB compare and page table read run in the accept cycle, the
// page table write-back in the resolve cycle. A result waits in an output register;
// resolve stalls only while it is full. After reset a clearing pass writes every
// page table entry, during which no request is accepted. Reset is synchronous, active low.
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_DEPTH   = TLB_DEPTH_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ADDR_W-1:0]      i_logical_address,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [FRAME_OUT_W-1:0] o_frame_index,
    output logic [PHYS_W-1:0]      o_physical_address,
    output logic [1:0]             o_outcome,
    output logic [PAGE_OUT_W-1:0]  o_load_page,
    output logic [COUNT_W-1:0]     o_address_count,
    output logic [COUNT_W-1:0]     o_fault_count,
    output logic [COUNT_W-1:0]     o_tlb_hit_count
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int RAW_W   = ADDR_W - OFFSET_BITS;
    localparam int RAW_WM  = (RAW_W > 0) ? RAW_W : 1;
    localparam int RAW_MAX = (1 << RAW_WM) - 1;

    typedef enum logic [2:0] {
        S_CLEAR   = 3'b001,
        S_IDLE    = 3'b010,
        S_RESOLVE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [PAGE_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_addr;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_next_free, n_next_free;
    logic               r_exhausted, n_exhausted;
    logic [COUNT_W-1:0] r_addr_total, n_addr_total;
    logic [COUNT_W-1:0] r_fault_total, n_fault_total;
    logic [COUNT_W-1:0] r_hit_total, n_hit_total;

    logic                   r_out_valid;
    logic [FRAME_OUT_W-1:0] r_o_frame;
    logic [PHYS_W-1:0]      r_o_phys;
    t_outcome               r_o_outcome;
    logic [PAGE_OUT_W-1:0]  r_o_load;

    logic               accept;
    logic               out_free;
    logic               resolve_go;
    logic [ADDR_W:0]    addr_shift;
    logic [RAW_WM-1:0]  page_rem;
    logic [PAGE_W-1:0]  in_page;

    logic               tlb_hit;
    logic [FRAME_W-1:0] tlb_frame;
    logic [FRAME_W:0]   pt_rdata;
    logic               pt_we;
    logic [PAGE_W-1:0]  pt_waddr;
    logic [FRAME_W:0]   pt_wdata;

    logic               res_have;
    logic [FRAME_W-1:0] res_frame;
    t_outcome           res_outcome;
    logic               ins_en;
    logic               fault_fill;
    logic [31:0]        phys_wide;

    // handshake
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign resolve_go = (r_state == S_RESOLVE) && out_free;

    // page number, reduced modulo the page table size by conditional subtraction
    always_comb begin
        addr_shift = {1'b0, i_logical_address} >> OFFSET_BITS;
        page_rem   = addr_shift[RAW_WM-1:0];
        for (int k = RAW_WM - 1; k >= 0; k--) begin
            if (((PAGE_COUNT << k) <= RAW_MAX) && (32'(page_rem) >= (PAGE_COUNT << k))) begin
                page_rem = page_rem - RAW_WM'(PAGE_COUNT << k);
            end
        end
        in_page = PAGE_W'(page_rem);
    end

    // tlb entry chain
    tlbpt_tlb #(
        .TLB_DEPTH(TLB_DEPTH),
        .PAGE_W   (PAGE_W),
        .FRAME_W  (FRAME_W)
    ) u_tlb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lookup_en   (accept),
        .i_lookup_page (in_page),
        .i_insert_en   (ins_en),
        .i_insert_page (r_page),
        .i_insert_frame(res_frame),
        .o_hit         (tlb_hit),
        .o_hit_frame   (tlb_frame)
    );

    // page table: valid bit over frame number
    tlbpt_ram #(
        .WIDTH(FRAME_W + 1),
        .DEPTH(PAGE_COUNT)
    ) u_page_table (
        .i_clk  (i_clk),
        .i_we   (pt_we),
        .i_waddr(pt_waddr),
        .i_wdata(pt_wdata),
        .i_re   (accept),
        .i_raddr(in_page),
        .o_rdata(pt_rdata)
    );

    // page table write port: clearing pass, then fault fills
    always_comb begin
        if (r_state == S_CLEAR) begin
            pt_we    = 1'b1;
            pt_waddr = r_clr_addr;
            pt_wdata = '0;
        end else begin
            pt_we    = fault_fill;
            pt_waddr = r_page;
            pt_wdata = {1'b1, r_next_free};
        end
    end

    // resolve: tlb hit, then page table hit, then fault
    always_comb begin
        res_have      = 1'b0;
        res_frame     = '0;
        res_outcome   = OUT_TLB_HIT;
        ins_en        = 1'b0;
        fault_fill    = 1'b0;
        n_next_free   = r_next_free;
        n_exhausted   = r_exhausted;
        n_addr_total  = r_addr_total;
        n_fault_total = r_fault_total;
        n_hit_total   = r_hit_total;
        if (resolve_go) begin
            n_addr_total = r_addr_total + COUNT_W'(1);
            priority if (tlb_hit) begin
                res_have    = 1'b1;
                res_frame   = tlb_frame;
                res_outcome = OUT_TLB_HIT;
                n_hit_total = r_hit_total + COUNT_W'(1);
            end else if (pt_rdata[FRAME_W]) begin
                res_have    = 1'b1;
                res_frame   = pt_rdata[FRAME_W-1:0];
                res_outcome = OUT_PT_HIT;
                ins_en      = 1'b1;
            end else begin
                n_fault_total = r_fault_total + COUNT_W'(1);
                if (!r_exhausted) begin
                    res_have    = 1'b1;
                    res_frame   = r_next_free;
                    res_outcome = OUT_FAULT_LOAD;
                    ins_en      = 1'b1;
                    fault_fill  = 1'b1;
                    if (r_next_free == FRAME_W'(FRAME_COUNT - 1)) begin
                        n_exhausted = 1'b1;
                    end else begin
                        n_next_free = r_next_free + FRAME_W'(1);
                    end
                end else begin
                    res_outcome = OUT_NO_FRAME;
                end
            end
        end
    end

    // physical address, low bits only
    assign phys_wide = (32'(res_frame) << OFFSET_BITS) | 32'(r_addr[OFFSET_BITS-1:0]);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == PAGE_W'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_next_free   <= '0;
            r_exhausted   <= 1'b0;
            r_addr_total  <= '0;
            r_fault_total <= '0;
            r_hit_total   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_next_free   <= n_next_free;
            r_exhausted   <= n_exhausted;
            r_addr_total  <= n_addr_total;
            r_fault_total <= n_fault_total;
            r_hit_total   <= n_hit_total;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + PAGE_W'(1);
            end
            if (resolve_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_logical_address;
            r_page <= in_page;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (resolve_go) begin
            r_o_frame   <= res_have ? FRAME_OUT_W'(res_frame) : '0;
            r_o_phys    <= res_have ? phys_wide[PHYS_W-1:0] : '0;
            r_o_outcome <= res_outcome;
            r_o_load    <= (res_outcome == OUT_FAULT_LOAD) ? PAGE_OUT_W'(r_page) : '0;
        end
    end

    // counts are held in the result register by taking them from the totals
    logic [COUNT_W-1:0] r_o_addr_cnt, r_o_fault_cnt, r_o_hit_cnt;

    always_ff @(posedge i_clk) begin
        if (resolve_go) begin
            r_o_addr_cnt  <= n_addr_total;
            r_o_fault_cnt <= n_fault_total;
            r_o_hit_cnt   <= n_hit_total;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_index      = r_o_frame;
    assign o_physical_address = r_o_phys;
    assign o_outcome          = r_o_outcome;
    assign o_load_page        = r_o_load;
    assign o_address_count    = r_o_addr_cnt;
    assign o_fault_count      = r_o_fault_cnt;
    assign o_tlb_hit_count    = r_o_hit_cnt;

`ifndef NO_ASSERTIONS
    // no request is taken while the page table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("request accepted during page table clearing");

    // every resolved request advances the address count by exactly one
    a_addr_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        resolve_go |=> (r_addr_total == $past(r_addr_total) + COUNT_W'(1)))
        else $error("address count did not step by one");

    // a load page is only named for a loaded fault
    a_load_only_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_outcome != OUT_FAULT_LOAD)) |-> (r_o_load == '0))
        else $error("load page set outside a loaded fault");

    // no free frame gives a zero frame and address
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_outcome == OUT_NO_FRAME)) |->
            ((r_o_frame == '0) && (r_o_phys == '0)))
        else $error("no free frame result carries a frame");
`endif

endmodule

>>> sim/tlb_page_table_translator_tb.sv
// Self-checking testbench for tlb_page_table_translator: drives address requests,
// predicts each translation from its own model of the TLB, page table and frame
// allocator, and compares every result field. Depends on tlbpt_pkg and the RTL.
module tlb_page_table_translator_tb;
    import tlbpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 750;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int IDLE_PERCENT    = 23;
    localparam int CALM_FIRST      = 300;
    localparam int CALM_LAST       = 450;
    localparam int HOT_PAGES       = 8;
    localparam int PAGE_W          = ADDR_W - OFFSET_BITS_DEF;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        bit                drain_first;
    } t_addr_req;

    typedef struct {
        logic [FRAME_OUT_W-1:0] frame;
        logic [PHYS_W-1:0]      phys;
        t_outcome               outcome;
        logic [PAGE_OUT_W-1:0]  load_page;
        logic [COUNT_W-1:0]     addr_count;
        logic [COUNT_W-1:0]     fault_count;
        logic [COUNT_W-1:0]     hit_count;
    } t_xlat;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [ADDR_W-1:0]      i_logical_address = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [FRAME_OUT_W-1:0] o_frame_index;
    logic [PHYS_W-1:0]      o_physical_address;
    logic [1:0]             o_outcome;
    logic [PAGE_OUT_W-1:0]  o_load_page;
    logic [COUNT_W-1:0]     o_address_count;
    logic [COUNT_W-1:0]     o_fault_count;
    logic [COUNT_W-1:0]     o_tlb_hit_count;

    // stimulus and expected translations
    t_addr_req address_queue[$];
    t_xlat     due_translations[$];
    bit        req_taken = 1'b0;
    int        requests_accepted = 0;
    int        mismatch_count = 0;
    int        stall_cycles = 0;

    // predictor state
    bit                     page_ok[PAGE_COUNT_DEF];
    logic [FRAME_OUT_W-1:0] page_frame[PAGE_COUNT_DEF];
    bit                     tlb_ok[TLB_DEPTH_DEF];
    logic [PAGE_W-1:0]      tlb_page[TLB_DEPTH_DEF];
    logic [FRAME_OUT_W-1:0] tlb_frame[TLB_DEPTH_DEF];
    int                     tlb_ptr = 0;
    logic [FRAME_OUT_W-1:0] next_frame = '0;
    bit                     out_of_frames = 1'b0;
    logic [COUNT_W-1:0]     addr_total = '0;
    logic [COUNT_W-1:0]     fault_total = '0;
    logic [COUNT_W-1:0]     hit_total = '0;

    tlb_page_table_translator uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_logical_address  (i_logical_address),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frame_index      (o_frame_index),
        .o_physical_address (o_physical_address),
        .o_outcome          (o_outcome),
        .o_load_page        (o_load_page),
        .o_address_count    (o_address_count),
        .o_fault_count      (o_fault_count),
        .o_tlb_hit_count    (o_tlb_hit_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // round-robin TLB fill
    function automatic void tlb_fill(input logic [PAGE_W-1:0] pg,
                                     input logic [FRAME_OUT_W-1:0] fr);
        tlb_ok[tlb_ptr]    = 1'b1;
        tlb_page[tlb_ptr]  = pg;
        tlb_frame[tlb_ptr] = fr;
        tlb_ptr = (tlb_ptr + 1) % TLB_DEPTH_DEF;
    endfunction

    // TLB lookup, then page table, then demand allocation of a frame
    function automatic t_xlat translate_address(input logic [ADDR_W-1:0] la);
        logic [PAGE_W-1:0]          pg;
        logic [OFFSET_BITS_DEF-1:0] off;
        t_xlat                      r;
        bit                         found;
        pg = la[ADDR_W-1:OFFSET_BITS_DEF];
        off = la[OFFSET_BITS_DEF-1:0];
        r.frame = '0;
        r.outcome = OUT_TLB_HIT;
        r.load_page = '0;
        found = 1'b0;
        addr_total++;
        for (int k = 0; k < TLB_DEPTH_DEF; k++) begin
            if (!found && tlb_ok[k] && tlb_page[k] == pg) begin
                found = 1'b1;
                r.frame = tlb_frame[k];
                hit_total++;
            end
        end
        if (!found) begin
            if (page_ok[pg]) begin
                r.frame = page_frame[pg];
                r.outcome = OUT_PT_HIT;
                tlb_fill(pg, r.frame);
            end else begin
                fault_total++;
                if (!out_of_frames) begin
                    r.frame = next_frame;
                    r.outcome = OUT_FAULT_LOAD;
                    r.load_page = pg;
                    page_ok[pg] = 1'b1;
                    page_frame[pg] = next_frame;
                    tlb_fill(pg, next_frame);
                    if (next_frame == FRAME_OUT_W'(FRAME_COUNT_DEF - 1)) begin
                        out_of_frames = 1'b1;
                    end else begin
                        next_frame++;
                    end
                end else begin
                    r.outcome = OUT_NO_FRAME;
                end
            end
        end
        r.phys = (r.outcome == OUT_NO_FRAME) ? '0 : PHYS_W'({r.frame, off});
        r.addr_count = addr_total;
        r.fault_count = fault_total;
        r.hit_count = hit_total;
        return r;
    endfunction

    function automatic bit calm_window();
        return requests_accepted >= CALM_FIRST && requests_accepted < CALM_LAST;
    endfunction

    // request driver, fed from the address queue
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (address_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (address_queue[0].drain_first && due_translations.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (!calm_window() && $urandom_range(99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_logical_address <= address_queue[0].addr;
                void'(address_queue.pop_front());
            end
        end
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready <= calm_window() || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // monitor: check results, then predict for newly accepted requests
    always @(posedge i_clk) begin
        t_xlat want;
        req_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_translations.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = due_translations.pop_front();
                    if (o_frame_index !== want.frame)
                        report_mismatch("frame_index", o_frame_index, want.frame);
                    if (o_physical_address !== want.phys)
                        report_mismatch("physical_address", o_physical_address, want.phys);
                    if (o_outcome !== want.outcome)
                        report_mismatch("outcome", o_outcome, int'(want.outcome));
                    if (o_load_page !== want.load_page)
                        report_mismatch("load_page", o_load_page, want.load_page);
                    if (o_address_count !== want.addr_count)
                        report_mismatch("address_count", o_address_count, want.addr_count);
                    if (o_fault_count !== want.fault_count)
                        report_mismatch("fault_count", o_fault_count, want.fault_count);
                    if (o_tlb_hit_count !== want.hit_count)
                        report_mismatch("tlb_hit_count", o_tlb_hit_count, want.hit_count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                due_translations.push_back(translate_address(i_logical_address));
                requests_accepted++;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_request(input logic [ADDR_W-1:0] addr, input bit drain);
        t_addr_req item;
        item.addr = addr;
        item.drain_first = drain;
        address_queue.push_back(item);
    endtask

    initial begin
        logic [PAGE_W-1:0] hot[$];
        logic [PAGE_W-1:0] seen[$];
        bit                touched[PAGE_COUNT_DEF];
        logic [PAGE_W-1:0] pg;
        int                pick;

        // directed: address extremes, repeat hits, then enough pages to evict the TLB
        add_request(16'h0000, 1'b0);
        add_request(16'hFFFF, 1'b0);
        add_request(16'h00FF, 1'b0);
        add_request(16'hFF00, 1'b0);
        add_request(16'h5AA5, 1'b0);
        add_request(16'hA55A, 1'b0);
        for (int p = 1; p <= TLB_DEPTH_DEF; p++) begin
            add_request({PAGE_W'(p), OFFSET_BITS_DEF'(p * 37)}, 1'b0);
        end
        // page 0 was evicted from the TLB, so this resolves from the page table
        add_request(16'h0011, 1'b0);
        touched = '{default: 1'b0};
        foreach (address_queue[n]) begin
            pg = address_queue[n].addr[ADDR_W-1:OFFSET_BITS_DEF];
            if (!touched[pg]) begin
                touched[pg] = 1'b1;
                seen.push_back(pg);
            end
        end

        // random: a small hot set, revisits of known pages and fresh pages
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            if (pick < 45 && hot.size() != 0) begin
                pg = hot[$urandom_range(hot.size() - 1)];
            end else begin
                if (pick < 75) begin
                    pg = seen[$urandom_range(seen.size() - 1)];
                end else begin
                    pg = PAGE_W'($urandom_range(PAGE_COUNT_DEF - 1));
                end
                hot.push_front(pg);
                if (hot.size() > HOT_PAGES) void'(hot.pop_back());
            end
            if (!touched[pg]) begin
                touched[pg] = 1'b1;
                seen.push_back(pg);
            end
            if ($urandom_range(99) < 3) hot.delete();
            // sender waits for every result before the first random request and mid-run
            add_request({pg, OFFSET_BITS_DEF'($urandom_range((1 << OFFSET_BITS_DEF) - 1))},
                        n == 0 || n == 400);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (address_queue.size() != 0 || i_in_valid || due_translations.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (due_translations.size() != 0) begin
            report_mismatch("results still due", due_translations.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
